// ===== design/mvdr_pkg.sv =====
// ============================================================================
// mvdr_pkg: shared types, codes and compare helpers
// Field widths, item and error codes, and the float-aware point compare used
// by the lookup cells of the mesh vertex dedupe / remap unit.
// ============================================================================
package mvdr_pkg;

  localparam int unsigned ACT_W    = 2;
  localparam int unsigned COORD_W  = 32;
  localparam int unsigned CORNER_W = 10;
  localparam int unsigned ERR_W    = 2;

  // item codes
  localparam logic [ACT_W-1:0] ACT_VERTEX   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_TRIANGLE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR    = 2'd2;

  // error codes
  localparam logic [ERR_W-1:0] ERR_NONE   = 2'd0;
  localparam logic [ERR_W-1:0] ERR_FULL   = 2'd1;
  localparam logic [ERR_W-1:0] ERR_CORNER = 2'd2;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
  } point_t;

  // control group from the sequencer to every cell
  typedef struct packed {
    logic start;   // new lookup: drop old hit and chain contents
    logic clr;     // new mesh: empty the cell
    logic rd_en;   // sweep read of one row
    logic wr_en;   // store the query at the write slot
  } cell_cmd_t;

  typedef struct packed {
    logic [ACT_W-1:0]    kind;
    logic [CORNER_W-1:0] new_index;
    logic                is_new;
    logic                triangle_kept;
    logic [CORNER_W-1:0] new_corner_a;
    logic [CORNER_W-1:0] new_corner_b;
    logic [CORNER_W-1:0] new_corner_c;
    logic [ERR_W-1:0]    error;
  } result_t;

  // float equality on bit patterns: NaN never equal, +0 equals -0
  function automatic logic coord_eq(input logic [COORD_W-1:0] a,
                                    input logic [COORD_W-1:0] b);
    logic [COORD_W-2:0] ma;
    logic [COORD_W-2:0] mb;
    logic               res;
    ma = a[COORD_W-2:0];
    mb = b[COORD_W-2:0];
    if (ma > 31'h7F80_0000 || mb > 31'h7F80_0000) begin
      res = 1'b0;
    end else if (ma == '0 && mb == '0) begin
      res = 1'b1;
    end else begin
      res = (a == b);
    end
    return res;
  endfunction

  function automatic logic point_eq(input point_t p, input point_t q);
    return coord_eq(p.x, q.x) && coord_eq(p.y, q.y) && coord_eq(p.z, q.z);
  endfunction

endpackage

// ===== design/mvdr_if.sv =====
// ============================================================================
// mvdr request / result channels
// Valid/ready channels carrying one request item and one result item.
// ============================================================================
interface mvdr_req_if import mvdr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACT_W-1:0]    action;
  logic [COORD_W-1:0]  x_bits;
  logic [COORD_W-1:0]  y_bits;
  logic [COORD_W-1:0]  z_bits;
  logic [CORNER_W-1:0] corner_a;
  logic [CORNER_W-1:0] corner_b;
  logic [CORNER_W-1:0] corner_c;

  modport source (output valid, action, x_bits, y_bits, z_bits,
                  corner_a, corner_b, corner_c, input ready);
  modport sink   (input valid, action, x_bits, y_bits, z_bits,
                  corner_a, corner_b, corner_c, output ready);
endinterface

interface mvdr_rsp_if import mvdr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACT_W-1:0]    kind;
  logic [CORNER_W-1:0] new_index;
  logic                is_new;
  logic                triangle_kept;
  logic [CORNER_W-1:0] new_corner_a;
  logic [CORNER_W-1:0] new_corner_b;
  logic [CORNER_W-1:0] new_corner_c;
  logic [ERR_W-1:0]    error;

  modport source (output valid, kind, new_index, is_new, triangle_kept,
                  new_corner_a, new_corner_b, new_corner_c, error, input ready);
  modport sink   (input valid, kind, new_index, is_new, triangle_kept,
                  new_corner_a, new_corner_b, new_corner_c, error, output ready);
endinterface

// ===== design/mesh_vertex_dedupe_remap_unit.sv =====
// Vertex request: time set by the row sweep over R = ceil(unique points / NUM_CELLS) rows
//   plus the hit chain walk; while the store is empty there is no sweep and no chain walk.
//   The result shows in the same cycle that the unit turns ready for the next request.
// Triangle request: three reads through the one remap read port. Clear, errors and unused
//   codes go straight to the finish step; it waits while the previous result is unaccepted.
// Async active-low reset empties the store at once (per-cell fill counts), no clearing pass.
// ============================================================================
// mesh_vertex_dedupe_remap_unit: vertex dedupe and triangle index remap
// A row of lookup cells holds the unique points; a vertex query is swept
// against all cells in parallel, one row per cycle, and any hit travels down
// the cell chain to the sequencer. Misses take the next merged index.
// ============================================================================
module mesh_vertex_dedupe_remap_unit import mvdr_pkg::*; #(
  parameter int unsigned MAX_VERTICES = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mvdr_req_if.sink    req_i,
  mvdr_rsp_if.source  rsp_o
);

  // cell row geometry: a power-of-two count of cells, rows per cell memory
  localparam int unsigned NUM_CELLS = (MAX_VERTICES >= 32) ? 32 :
                                      (MAX_VERTICES >= 16) ? 16 :
                                      (MAX_VERTICES >= 8)  ? 8 : 4;
  localparam int unsigned CELL_W = $clog2(NUM_CELLS);
  localparam int unsigned ROWS   = (MAX_VERTICES + NUM_CELLS - 1) / NUM_CELLS;
  localparam int unsigned ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned SLOT_W = ROW_W + CELL_W;
  localparam int unsigned CNT_W  = $clog2(MAX_VERTICES + 1);
  localparam int unsigned IDX_W  = $clog2(MAX_VERTICES);
  localparam int unsigned SEQ_W  = CELL_W + 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_DRAIN,
    ST_RESOLVE,
    ST_TRI_RD,
    ST_FINISH
  } state_e;

  state_e              state_q;
  logic [CNT_W-1:0]    unique_q;
  logic [CNT_W-1:0]    loaded_q;
  logic [ROW_W-1:0]    wr_row_q;
  logic [CELL_W-1:0]   wr_cell_q;
  logic [ROW_W:0]      rows_used_q;
  logic [ROW_W-1:0]    row_q;
  logic [SEQ_W-1:0]    seq_q;
  logic [CORNER_W-1:0] na_q;
  logic [CORNER_W-1:0] nb_q;
  result_t             res_q;
  result_t             rsp_q;
  logic                rsp_valid_q;

  // request payload held for the duration of the item
  point_t              query_q;
  logic [CORNER_W-1:0] corner_a_q;
  logic [CORNER_W-1:0] corner_b_q;
  logic [CORNER_W-1:0] corner_c_q;

  logic                req_fire;
  logic                rsp_free;
  logic                rsp_load;
  result_t             res_init;
  cell_cmd_t           cmd;
  logic [ROW_W-1:0]    cell_row;
  logic                chain_hit [NUM_CELLS+1];
  logic [SLOT_W-1:0]   chain_idx [NUM_CELLS+1];
  logic [31:0]         found_w;
  logic [CORNER_W-1:0] found_idx;
  logic [CORNER_W-1:0] remap_rdata;
  logic [CORNER_W-1:0] rd_corner;
  logic [31:0]         rd_corner_w;
  logic [31:0]         loaded_w;
  logic                corner_bad;

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign rsp_free    = !rsp_valid_q || rsp_o.ready;
  assign rsp_load    = (state_q == ST_FINISH) && rsp_free;

  // ---------------------------------------------------------------------------
  // cell controls
  // ---------------------------------------------------------------------------
  always_comb begin
    cmd.start = req_fire && (req_i.action == ACT_VERTEX);
    cmd.clr   = req_fire && (req_i.action == ACT_CLEAR);
    cmd.rd_en = (state_q == ST_SWEEP);
    cmd.wr_en = (state_q == ST_RESOLVE) && !chain_hit[NUM_CELLS];
  end

  assign cell_row = (state_q == ST_RESOLVE) ? wr_row_q : row_q;

  // head of the chain carries nothing
  assign chain_hit[0] = 1'b0;
  assign chain_idx[0] = '0;

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    mvdr_cell #(
      .ROWS    (ROWS),
      .ROW_W   (ROW_W),
      .CELL_W  (CELL_W),
      .CELL_ID (i)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cmd_i      (cmd),
      .row_i      (cell_row),
      .wr_sel_i   (wr_cell_q),
      .query_i    (query_q),
      .link_hit_i (chain_hit[i]),
      .link_idx_i (chain_idx[i]),
      .link_hit_o (chain_hit[i+1]),
      .link_idx_o (chain_idx[i+1])
    );
  end

  // merged index: the hit slot, or the next free slot on a miss (10-bit view)
  assign found_w   = chain_hit[NUM_CELLS] ? 32'(chain_idx[NUM_CELLS]) : 32'(unique_q);
  assign found_idx = found_w[CORNER_W-1:0];

  // ---------------------------------------------------------------------------
  // remap table
  // ---------------------------------------------------------------------------
  always_comb begin
    case (seq_q)
      SEQ_W'(0): rd_corner = corner_a_q;
      SEQ_W'(1): rd_corner = corner_b_q;
      default:   rd_corner = corner_c_q;
    endcase
  end

  assign rd_corner_w = 32'(rd_corner);
  assign loaded_w    = 32'(loaded_q);

  mvdr_remap_mem #(
    .DEPTH  (MAX_VERTICES),
    .ADDR_W (IDX_W)
  ) u_remap (
    .clk_i     (clk_i),
    .wr_en_i   (state_q == ST_RESOLVE),
    .wr_addr_i (loaded_w[IDX_W-1:0]),
    .wr_data_i (found_idx),
    .rd_en_i   ((state_q == ST_TRI_RD) && (seq_q < SEQ_W'(3))),
    .rd_addr_i (rd_corner_w[IDX_W-1:0]),
    .rd_data_o (remap_rdata)
  );

  // any corner at or above the loaded count drops the triangle
  assign corner_bad = (32'(req_i.corner_a) >= loaded_w) ||
                      (32'(req_i.corner_b) >= loaded_w) ||
                      (32'(req_i.corner_c) >= loaded_w);

  // starting result of a request: kind echo plus any error seen at acceptance
  always_comb begin
    res_init      = '0;
    res_init.kind = req_i.action;
    if ((req_i.action == ACT_VERTEX) && (32'(loaded_q) >= 32'(MAX_VERTICES))) begin
      res_init.error = ERR_FULL;
    end else if ((req_i.action == ACT_TRIANGLE) && corner_bad) begin
      res_init.error = ERR_CORNER;
    end
  end

  // ---------------------------------------------------------------------------
  // request payload capture
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      query_q.x  <= req_i.x_bits;
      query_q.y  <= req_i.y_bits;
      query_q.z  <= req_i.z_bits;
      corner_a_q <= req_i.corner_a;
      corner_b_q <= req_i.corner_b;
      corner_c_q <= req_i.corner_c;
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      unique_q    <= '0;
      loaded_q    <= '0;
      wr_row_q    <= '0;
      wr_cell_q   <= '0;
      rows_used_q <= '0;
      row_q       <= '0;
      seq_q       <= '0;
      na_q        <= '0;
      nb_q        <= '0;
      res_q       <= '0;
      rsp_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (rsp_valid_q && rsp_o.ready && !rsp_load) begin
        rsp_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (req_fire) begin
            res_q <= res_init;
            row_q <= '0;
            seq_q <= '0;
            unique case (req_i.action)
              ACT_VERTEX: begin
                if (32'(loaded_q) >= 32'(MAX_VERTICES)) begin
                  state_q <= ST_FINISH;
                end else if (rows_used_q == '0) begin
                  state_q <= ST_RESOLVE;
                end else begin
                  state_q <= ST_SWEEP;
                end
              end
              ACT_TRIANGLE: begin
                if (corner_bad) begin
                  state_q <= ST_FINISH;
                end else begin
                  state_q <= ST_TRI_RD;
                end
              end
              ACT_CLEAR: begin
                unique_q    <= '0;
                loaded_q    <= '0;
                wr_row_q    <= '0;
                wr_cell_q   <= '0;
                rows_used_q <= '0;
                state_q     <= ST_FINISH;
              end
              default: begin
                state_q <= ST_FINISH;
              end
            endcase
          end
        end

        // one row of every cell per cycle
        ST_SWEEP: begin
          if ({1'b0, row_q} + 1'b1 == rows_used_q) begin
            seq_q   <= '0;
            state_q <= ST_DRAIN;
          end else begin
            row_q <= row_q + 1'b1;
          end
        end

        // read latency, compare, then the hit walks the full chain
        ST_DRAIN: begin
          if (seq_q == SEQ_W'(NUM_CELLS + 1)) begin
            state_q <= ST_RESOLVE;
          end else begin
            seq_q <= seq_q + 1'b1;
          end
        end

        ST_RESOLVE: begin
          res_q.new_index <= found_idx;
          if (!chain_hit[NUM_CELLS]) begin
            res_q.is_new <= 1'b1;
            unique_q     <= unique_q + 1'b1;
            if (wr_cell_q == '0) begin
              rows_used_q <= rows_used_q + 1'b1;
            end
            if (wr_cell_q == CELL_W'(NUM_CELLS - 1)) begin
              wr_cell_q <= '0;
              wr_row_q  <= wr_row_q + 1'b1;
            end else begin
              wr_cell_q <= wr_cell_q + 1'b1;
            end
          end
          loaded_q <= loaded_q + 1'b1;
          state_q  <= ST_FINISH;
        end

        // issue reads for corners a, b, c; read data arrives in the next cycle
        ST_TRI_RD: begin
          seq_q <= seq_q + 1'b1;
          if (seq_q == SEQ_W'(1)) begin
            na_q <= remap_rdata;
          end
          if (seq_q == SEQ_W'(2)) begin
            nb_q <= remap_rdata;
          end
          if (seq_q == SEQ_W'(3)) begin
            res_q.new_corner_a  <= na_q;
            res_q.new_corner_b  <= nb_q;
            res_q.new_corner_c  <= remap_rdata;
            res_q.triangle_kept <= (na_q != nb_q) && (nb_q != remap_rdata) &&
                                   (na_q != remap_rdata);
            state_q             <= ST_FINISH;
          end
        end

        ST_FINISH: begin
          if (rsp_free) begin
            rsp_q       <= res_q;
            rsp_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign rsp_o.valid         = rsp_valid_q;
  assign rsp_o.kind          = rsp_q.kind;
  assign rsp_o.new_index     = rsp_q.new_index;
  assign rsp_o.is_new        = rsp_q.is_new;
  assign rsp_o.triangle_kept = rsp_q.triangle_kept;
  assign rsp_o.new_corner_a  = rsp_q.new_corner_a;
  assign rsp_o.new_corner_b  = rsp_q.new_corner_b;
  assign rsp_o.new_corner_c  = rsp_q.new_corner_c;
  assign rsp_o.error         = rsp_q.error;

endmodule

// ===== design/mvdr_cell.sv =====
// ============================================================================
// mvdr_cell: one lookup cell
// Holds one column of the unique point store, compares one row per sweep
// cycle against the query, and passes the hit along the result chain.
// ============================================================================
module mvdr_cell import mvdr_pkg::*; #(
  parameter int unsigned ROWS    = 32,
  parameter int unsigned ROW_W   = 5,
  parameter int unsigned CELL_W  = 5,
  parameter int unsigned CELL_ID = 0
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cell_cmd_t               cmd_i,
  input  logic [ROW_W-1:0]        row_i,
  input  logic [CELL_W-1:0]       wr_sel_i,
  input  point_t                  query_i,
  input  logic                    link_hit_i,
  input  logic [ROW_W+CELL_W-1:0] link_idx_i,
  output logic                    link_hit_o,
  output logic [ROW_W+CELL_W-1:0] link_idx_o
);

  point_t                  mem [ROWS];
  point_t                  rdata_q;
  logic [ROW_W:0]          fill_q;
  logic                    cmp_en_q;
  logic [ROW_W-1:0]        cmp_row_q;
  logic                    hit_q;
  logic [ROW_W+CELL_W-1:0] idx_q;
  logic                    lhit_q;
  logic [ROW_W+CELL_W-1:0] lidx_q;
  logic                    wr_here;
  logic                    match;

  assign wr_here = cmd_i.wr_en && (wr_sel_i == CELL_W'(CELL_ID));
  assign match   = cmp_en_q && point_eq(rdata_q, query_i);

  always_ff @(posedge clk_i) begin
    if (wr_here) begin
      mem[row_i] <= query_i;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[row_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q    <= '0;
      cmp_en_q  <= 1'b0;
      cmp_row_q <= '0;
      hit_q     <= 1'b0;
      idx_q     <= '0;
      lhit_q    <= 1'b0;
      lidx_q    <= '0;
    end else begin
      if (cmd_i.clr) begin
        fill_q <= '0;
      end else if (wr_here) begin
        fill_q <= fill_q + 1'b1;
      end
      // only rows this cell has filled take part
      cmp_en_q  <= cmd_i.rd_en && ({1'b0, row_i} < fill_q);
      cmp_row_q <= row_i;
      if (cmd_i.start) begin
        hit_q  <= 1'b0;
        lhit_q <= 1'b0;
      end else begin
        if (match) begin
          hit_q <= 1'b1;
          idx_q <= {cmp_row_q, CELL_W'(CELL_ID)};
        end
        lhit_q <= hit_q | link_hit_i;
        lidx_q <= hit_q ? idx_q : link_idx_i;
      end
    end
  end

  assign link_hit_o = lhit_q;
  assign link_idx_o = lidx_q;

endmodule

// ===== design/mvdr_remap_mem.sv =====
// ============================================================================
// mvdr_remap_mem: old-to-new index table
// One write port, one read port with registered read data.
// ============================================================================
module mvdr_remap_mem import mvdr_pkg::*; #(
  parameter int unsigned DEPTH  = 1024,
  parameter int unsigned ADDR_W = 10
) (
  input  logic                clk_i,
  input  logic                wr_en_i,
  input  logic [ADDR_W-1:0]   wr_addr_i,
  input  logic [CORNER_W-1:0] wr_data_i,
  input  logic                rd_en_i,
  input  logic [ADDR_W-1:0]   rd_addr_i,
  output logic [CORNER_W-1:0] rd_data_o
);

  logic [CORNER_W-1:0] mem [DEPTH];
  logic [CORNER_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rdata_q;

endmodule
